/* sv/slh_pkg.sv */
// ----------------------------------------------------------------------------
// slh_pkg
// Shared types, constants and mixing functions of the strided lookup3 hash.
// ----------------------------------------------------------------------------
package slh_pkg;

    // stream payload layout
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;
    localparam int WORD_LSB   = 0;
    localparam int LEN_LSB    = 32;
    localparam int SEED_LSB   = 64;

    // item kinds carried in tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef;

    // len / 10000 as ((len >> 4) * STRIDE_RECIP) >> STRIDE_SHIFT, exact for 28-bit operands
    localparam int          STRIDE_PRE_SHIFT = 4;
    localparam int          STRIDE_OPND_W    = 32 - STRIDE_PRE_SHIFT;
    localparam int          STRIDE_RECIP_W   = 29;
    localparam int          STRIDE_PROD_W    = STRIDE_OPND_W + STRIDE_RECIP_W;
    localparam int          STRIDE_SHIFT     = 38;
    localparam int          STRIDE_W         = STRIDE_PROD_W - STRIDE_SHIFT;
    localparam logic [STRIDE_RECIP_W-1:0] STRIDE_RECIP = 29'd439804652;

    // period length 3d and span 12d
    localparam int PHASE_W = STRIDE_W + 2;
    localparam int SPAN_W  = PHASE_W + 2;
    localparam int WORDS_W = 31;

    // mixing register slots
    localparam logic [1:0] SLOT_A    = 2'd0;
    localparam logic [1:0] SLOT_B    = 2'd1;
    localparam logic [1:0] SLOT_C    = 2'd2;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    // mix runs in three double-row steps, final in four
    localparam logic [1:0] MIX_LAST_STEP   = 2'd2;
    localparam logic [1:0] FINAL_LAST_STEP = 2'd3;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic        is_start;
        logic        zero_len;
        logic        apply;
        logic        last;
        logic [1:0]  slot;
        logic [31:0] word;
    } q_entry_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } abc_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // two rows of the lookup3 mix per step
    function automatic abc_t mix_step(input abc_t s, input logic [1:0] step);
        abc_t r;
        r = s;
        case (step)
            2'd0:
            begin
                r.a = (r.a - r.c) ^ rotl32(r.c, 4);
                r.c = r.c + r.b;
                r.b = (r.b - r.a) ^ rotl32(r.a, 6);
                r.a = r.a + r.c;
            end
            2'd1:
            begin
                r.c = (r.c - r.b) ^ rotl32(r.b, 8);
                r.b = r.b + r.a;
                r.a = (r.a - r.c) ^ rotl32(r.c, 16);
                r.c = r.c + r.b;
            end
            2'd2:
            begin
                r.b = (r.b - r.a) ^ rotl32(r.a, 19);
                r.a = r.a + r.c;
                r.c = (r.c - r.b) ^ rotl32(r.b, 4);
                r.b = r.b + r.a;
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    // two rows of the final avalanche per step, the last step has one
    function automatic abc_t final_step(input abc_t s, input logic [1:0] step);
        abc_t r;
        r = s;
        case (step)
            2'd0:
            begin
                r.c = (r.c ^ r.b) - rotl32(r.b, 14);
                r.a = (r.a ^ r.c) - rotl32(r.c, 11);
            end
            2'd1:
            begin
                r.b = (r.b ^ r.a) - rotl32(r.a, 25);
                r.c = (r.c ^ r.b) - rotl32(r.b, 16);
            end
            2'd2:
            begin
                r.a = (r.a ^ r.c) - rotl32(r.c, 4);
                r.b = (r.b ^ r.a) - rotl32(r.a, 14);
            end
            default:
            begin
                r.c = (r.c ^ r.b) - rotl32(r.b, 24);
            end
        endcase
        return r;
    endfunction

endpackage

/* sv/slh_front.sv */
// ----------------------------------------------------------------------------
// slh_front
// Accepts stream transactions, tracks message position and stride, and
// classifies each word into a queue entry for the mixing back end.
// ----------------------------------------------------------------------------
module slh_front
    import slh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // data_word, length_bytes, seed
    input  logic                 s_tuser,   // cmd
    input  logic                 q_full,
    output logic                 q_push,
    output q_entry_t             q_wdata
);

    // input register
    logic                item_valid_reg;
    logic                cmd_reg;
    logic [31:0]         word_reg;
    logic [31:0]         len_reg;
    logic [31:0]         seed_reg;
    logic [STRIDE_W-1:0] stride_reg;

    // message position
    logic [31:0]         bytes_left_reg;
    logic [PHASE_W-1:0]  period_words_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [WORDS_W-1:0]  words_to_come_reg;

    logic [STRIDE_PROD_W-1:0] stride_prod;
    logic                accept;
    logic                item_done;
    logic                need_push;
    logic                is_start;
    logic [STRIDE_W-1:0] stride1;
    logic [PHASE_W-1:0]  period_start;
    logic [31:0]         init_val;
    logic [WORDS_W-1:0]  words_start;
    logic                msg_open;
    logic                in_loop;
    logic                head_slot;
    logic                tail_ok;
    logic [3:0]          tail_n;
    logic [31:0]         tail_mask;
    logic [1:0]          slot;
    logic                apply;
    logic                last;
    logic [PHASE_W-1:0]  phase_inc;
    logic                wrap;

    // stride divide by reciprocal multiply, registered with the transaction
    assign stride_prod = STRIDE_PROD_W'(s_tdata[LEN_LSB+STRIDE_PRE_SHIFT +: STRIDE_OPND_W])
                       * STRIDE_PROD_W'(STRIDE_RECIP);

    assign accept    = s_tvalid && s_tready;
    assign item_done = item_valid_reg && (!need_push || !q_full);
    assign s_tready  = !item_valid_reg || item_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (item_done)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            word_reg   <= s_tdata[WORD_LSB +: 32];
            len_reg    <= s_tdata[LEN_LSB +: 32];
            seed_reg   <= s_tdata[SEED_LSB +: 32];
            stride_reg <= stride_prod[STRIDE_SHIFT +: STRIDE_W];
        end
    end

    // start values
    assign is_start     = (cmd_reg == CMD_START);
    assign stride1      = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
    assign period_start = PHASE_W'({stride1, 1'b0}) + PHASE_W'(stride1);
    assign init_val     = HASH_INIT + len_reg + seed_reg;
    assign words_start  = WORDS_W'(len_reg[31:2]) + WORDS_W'(|len_reg[1:0]);

    // data word classification
    assign msg_open  = (words_to_come_reg != '0);
    assign in_loop   = (bytes_left_reg > 32'(span_reg));
    assign head_slot = (phase_reg < PHASE_W'(3));
    assign tail_n    = bytes_left_reg[3:0] - {phase_reg[1:0], 2'b00};
    assign tail_ok   = !in_loop && head_slot && (bytes_left_reg <= 32'd12)
                     && ({phase_reg[1:0], 2'b00} < bytes_left_reg[3:0]);

    always_comb
    begin
        case (tail_n)
            4'd1:    tail_mask = 32'h0000_00ff;
            4'd2:    tail_mask = 32'h0000_ffff;
            4'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
    end

    assign slot      = ((in_loop && head_slot) || tail_ok) ? phase_reg[1:0] : SLOT_NONE;
    assign apply     = in_loop && (phase_reg == PHASE_W'(2));
    assign last      = (words_to_come_reg == WORDS_W'(1));
    assign phase_inc = phase_reg + PHASE_W'(1);
    assign wrap      = (phase_inc >= period_words_reg);

    // skipped words need no back-end work unless they close the message
    assign need_push = is_start || (msg_open && ((slot != SLOT_NONE) || last));
    assign q_push    = item_valid_reg && need_push && !q_full;

    always_comb
    begin
        q_wdata.is_start = is_start;
        q_wdata.zero_len = (len_reg == '0);
        q_wdata.apply    = !is_start && apply;
        q_wdata.last     = !is_start && last;
        q_wdata.slot     = is_start ? SLOT_NONE : slot;
        if (is_start)
        begin
            q_wdata.word = init_val;
        end
        else if (in_loop)
        begin
            q_wdata.word = word_reg;
        end
        else
        begin
            q_wdata.word = word_reg & tail_mask;
        end
    end

    // message position update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            period_words_reg  <= PHASE_W'(3);
            span_reg          <= SPAN_W'(12);
            phase_reg         <= '0;
            words_to_come_reg <= '0;
        end
        else if (item_done)
        begin
            if (is_start)
            begin
                bytes_left_reg    <= len_reg;
                period_words_reg  <= period_start;
                span_reg          <= SPAN_W'({period_start, 2'b00});
                phase_reg         <= '0;
                words_to_come_reg <= words_start;
            end
            else if (msg_open)
            begin
                phase_reg         <= wrap ? '0 : phase_inc;
                words_to_come_reg <= words_to_come_reg - WORDS_W'(1);
                if (wrap && in_loop)
                begin
                    bytes_left_reg <= bytes_left_reg - 32'(span_reg);
                end
            end
        end
    end

endmodule

/* sv/slh_queue.sv */
// ----------------------------------------------------------------------------
// slh_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module slh_queue
    import slh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     pop,
    output q_entry_t head,
    output logic     head_valid
);

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue fill count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

/* sv/slh_back.sv */
// ----------------------------------------------------------------------------
// slh_back
// Mixing engine: adds the period words into a, b, c, runs mix and final
// avalanche in double-row steps, and holds the hash in an output register.
// ----------------------------------------------------------------------------
module slh_back
    import slh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_entry_t              head,
    input  logic                  head_valid,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // hash
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MIX   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]  st_reg;
    logic [1:0]  step_reg;
    abc_t        abc_reg;
    logic [31:0] pend_reg [3];
    logic        out_valid_reg;
    logic [31:0] hash_reg;

    logic        out_free;
    logic        needs_idle;
    logic        engine_idle;
    logic        zero_start;
    logic        fin_emit;
    logic        out_load;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    abc_t        sum_abc;
    abc_t        mix_abc;
    abc_t        fin_abc;

    assign out_free    = !out_valid_reg || m_tready;
    assign engine_idle = (st_reg == ST_IDLE);
    assign needs_idle  = head.is_start || head.apply || head.last;
    assign zero_start  = head.is_start && head.zero_len;

    // pending word writes go on while the engine mixes
    assign pop = head_valid
              && (!needs_idle || (engine_idle && (!zero_start || out_free)));

    // period words into a, b, c
    assign add_a     = (head.slot == SLOT_A) ? head.word : pend_reg[0];
    assign add_b     = (head.slot == SLOT_B) ? head.word : pend_reg[1];
    assign add_c     = (head.slot == SLOT_C) ? head.word : pend_reg[2];
    assign sum_abc.a = abc_reg.a + add_a;
    assign sum_abc.b = abc_reg.b + add_b;
    assign sum_abc.c = abc_reg.c + add_c;

    assign mix_abc  = mix_step(abc_reg, step_reg);
    assign fin_abc  = final_step(abc_reg, step_reg);
    assign fin_emit = (st_reg == ST_FINAL) && (step_reg == FINAL_LAST_STEP) && out_free;
    assign out_load = fin_emit || (pop && zero_start);

    // engine sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            step_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (pop && head.apply)
                    begin
                        st_reg <= ST_MIX;
                    end
                    else if (pop && head.last)
                    begin
                        st_reg <= ST_FINAL;
                    end
                end
                ST_MIX:
                begin
                    if (step_reg == MIX_LAST_STEP)
                    begin
                        st_reg   <= ST_IDLE;
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                ST_FINAL:
                begin
                    if (step_reg != FINAL_LAST_STEP)
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                    else if (out_free)
                    begin
                        st_reg   <= ST_IDLE;
                        step_reg <= '0;
                    end
                end
                default:
                begin
                    st_reg   <= ST_IDLE;
                    step_reg <= '0;
                end
            endcase
        end
    end

    // mixing registers and pending words
    always_ff @(posedge clk)
    begin
        if (pop && head.is_start)
        begin
            abc_reg.a   <= head.word;
            abc_reg.b   <= head.word;
            abc_reg.c   <= head.word;
            pend_reg[0] <= '0;
            pend_reg[1] <= '0;
            pend_reg[2] <= '0;
        end
        else if (pop && (head.apply || head.last))
        begin
            abc_reg     <= sum_abc;
            pend_reg[0] <= '0;
            pend_reg[1] <= '0;
            pend_reg[2] <= '0;
        end
        else
        begin
            if (pop && (head.slot != SLOT_NONE))
            begin
                pend_reg[head.slot] <= head.word;
            end
            if (st_reg == ST_MIX)
            begin
                abc_reg <= mix_abc;
            end
            else if ((st_reg == ST_FINAL) && (step_reg != FINAL_LAST_STEP))
            begin
                abc_reg <= fin_abc;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_emit)
        begin
            hash_reg <= fin_abc.c;
        end
        else if (pop && zero_start)
        begin
            hash_reg <= head.word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hash_reg;

`ifndef SYNTHESIS
    a_busy_no_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (!engine_idle && pop) |-> !(head.is_start || head.apply || head.last))
        else $error("ordered entry taken while engine busy");

    a_mix_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_MIX) |-> (step_reg <= MIX_LAST_STEP))
        else $error("mix step out of range");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_emit |=> m_tvalid)
        else $error("final hash not presented");
`endif

endmodule

/* sv/strided_lookup3_hash_core.sv */
// ----------------------------------------------------------------------------
// strided_lookup3_hash_core
// Strided lookup3 hash over a byte buffer streamed as little-endian words.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser 0 starts a message (length and seed in tdata),
// tuser 1 carries the next 32-bit buffer word. Output stream m_* carries one
// 32-bit hash per message, after its last word or after a zero-length
// start. A new start drops any running message; stray words are ignored.
// The front registers each transaction, works out the stride with one
// reciprocal multiply and classifies the word; a four-entry queue feeds the
// mixing engine. The input takes one transaction per cycle while the queue
// has room. Each mixed period costs the engine an add step and then the
// mix steps; skipped words cost nothing. The last word is added in and
// followed by the final avalanche steps, whose result is loaded into the
// output register. A stalled receiver holds the hash in the output
// register; the engine then waits and the queue fills before the input
// deasserts tready. Reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module strided_lookup3_hash_core
    import slh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // data_word, length_bytes, seed
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // hash
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_head_valid;
    q_entry_t q_wdata;
    q_entry_t q_head;

    // classify transactions
    slh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // decoupling queue
    slh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wdata      (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    // mixing engine and output register
    slh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
